// ===== rtl/vector_normalize_3d_assert.svh =====
`ifndef VECTOR_NORMALIZE_3D_ASSERT_SVH
`define VECTOR_NORMALIZE_3D_ASSERT_SVH
// Assertion macros: implication checked on every clock, disabled in reset.
`define VN3_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define VN3_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/vn3_pkg.sv =====
package vn3_pkg;
    localparam int FRAC_BITS = 16;
    localparam int COMP_W    = 32;
    localparam int MAG_W     = 33;
    localparam int SUMSQ_W   = 66;
    localparam int LEN_W     = 33;
    localparam int THR_W     = 16;
    localparam int DATA_W    = 128;
    localparam logic [THR_W-1:0] THR_RESET = 16'd1;
endpackage

// ===== rtl/vector_normalize_3d.sv =====
// vector_normalize_3d: normalizes (x, y, z) of a signed fixed-point vector to unit length and
// sets w to 1.0; when floor(sqrt(x*x+y*y+z*z)) is below the zero threshold (or is zero) the
// vector passes unchanged with tuser (was_zero) high. A request is taken every cycle unless
// the output stalls. Magnitude, square, sum stages feed the bit-per-stage root and the three
// bit-per-stage restoring dividers. tdata carries x, y, z, w, 32 bits each, x lowest. A stall
// of the output freezes the whole pipeline. The threshold may be written only while idle.
module vector_normalize_3d #(
    parameter int FRAC_BITS = vn3_pkg::FRAC_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [15:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // in_x, in_y, in_z, in_w
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // out_x, out_y, out_z, out_w
    output logic         m_axis_tuser    // was_zero
);
    localparam int CW = vn3_pkg::COMP_W;
    localparam int MW = vn3_pkg::MAG_W;
    localparam int SW = vn3_pkg::SUMSQ_W;
    localparam int LW = vn3_pkg::LEN_W;
    localparam int NS = LW;                 // root stages
    localparam int QW = MW + FRAC_BITS;     // dividend / quotient width
    localparam int ND = QW;                 // divide stages
    localparam int RW = LW + 1;             // remainder width

    logic adv;
    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;
    assign o_cfg_ready = 1'b1;

    logic [15:0] r_thr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_thr <= vn3_pkg::THR_RESET;
        else if (i_cfg_valid) r_thr <= i_cfg_data;
    end

    // stage A: magnitudes
    logic [CW-1:0] r_a_in [4];
    logic [MW-1:0] r_a_m [3];
    logic [2:0] r_a_ng;
    logic r_a_v;
    // stage B: squares
    logic [CW-1:0] r_b_in [4];
    logic [MW-1:0] r_b_m [3];
    logic [2:0] r_b_ng;
    logic [SW-1:0] r_b_sq [3];
    logic r_b_v;
    // stage C: sum
    logic [CW-1:0] r_c_in [4];
    logic [MW-1:0] r_c_m [3];
    logic [2:0] r_c_ng;
    logic [SW-1:0] r_c_sum;
    logic r_c_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0; r_b_v <= 1'b0; r_c_v <= 1'b0;
        end else if (adv) begin
            r_a_v <= s_axis_tvalid; r_b_v <= r_a_v; r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) r_a_in[k] <= s_axis_tdata[k*CW +: CW];
            for (int k = 0; k < 3; k++) begin
                r_a_ng[k] <= s_axis_tdata[k*CW + CW-1];
                r_a_m[k]  <= s_axis_tdata[k*CW + CW-1]
                    ? MW'(-{1'b1, s_axis_tdata[k*CW +: CW]})
                    : {1'b0, s_axis_tdata[k*CW +: CW]};
            end
            r_b_in <= r_a_in; r_b_m <= r_a_m; r_b_ng <= r_a_ng;
            for (int k = 0; k < 3; k++) r_b_sq[k] <= SW'(r_a_m[k]) * SW'(r_a_m[k]);
            r_c_in <= r_b_in; r_c_m <= r_b_m; r_c_ng <= r_b_ng;
            r_c_sum <= r_b_sq[0] + r_b_sq[1] + r_b_sq[2];
        end
    end

    // root pipeline: one result bit per stage, restoring
    logic [SW-1:0] r_s_rem [NS+1];
    logic [LW-1:0] r_s_root [NS+1];
    logic [CW-1:0] r_s_in [NS+1][4];
    logic [MW-1:0] r_s_m [NS+1][3];
    logic [2:0] r_s_ng [NS+1];
    logic r_s_v [NS+1];
    always_comb begin
        r_s_rem[0] = r_c_sum; r_s_root[0] = '0; r_s_in[0] = r_c_in;
        r_s_m[0] = r_c_m; r_s_ng[0] = r_c_ng; r_s_v[0] = r_c_v;
    end
    for (genvar g = 0; g < NS; g++) begin : g_sqrt
        localparam int B = NS - 1 - g;
        logic [SW+1:0] trial;
        logic [SW+1:0] rootsq;
        assign trial  = {2'b0, r_s_rem[g]} >> (2*B);
        assign rootsq = (SW+2)'({r_s_root[g], 2'b01});
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_s_v[g+1] <= 1'b0;
            else if (adv) r_s_v[g+1] <= r_s_v[g];
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_s_in[g+1] <= r_s_in[g]; r_s_m[g+1] <= r_s_m[g]; r_s_ng[g+1] <= r_s_ng[g];
                if (trial >= rootsq) begin
                    r_s_rem[g+1]  <= r_s_rem[g] - SW'(rootsq << (2*B));
                    r_s_root[g+1] <= {r_s_root[g][LW-2:0], 1'b1};
                end else begin
                    r_s_rem[g+1]  <= r_s_rem[g];
                    r_s_root[g+1] <= {r_s_root[g][LW-2:0], 1'b0};
                end
            end
        end
    end

    // zero decision, then dividers
    logic [LW-1:0] len_f;
    logic zero_f;
    assign len_f = r_s_root[NS];
    assign zero_f = (len_f < LW'(r_thr)) || (len_f == '0);

    logic [RW-1:0] r_d_rem [ND+1][3];
    logic [QW-1:0] r_d_q [ND+1][3];
    logic [LW-1:0] r_d_len [ND+1];
    logic [CW-1:0] r_d_in [ND+1][4];
    logic [2:0] r_d_ng [ND+1];
    logic r_d_z [ND+1];
    logic r_d_v [ND+1];
    always_comb begin
        r_d_len[0] = len_f; r_d_in[0] = r_s_in[NS]; r_d_ng[0] = r_s_ng[NS];
        r_d_z[0] = zero_f; r_d_v[0] = r_s_v[NS];
        for (int k = 0; k < 3; k++) begin
            r_d_rem[0][k] = '0;
            r_d_q[0][k] = {r_s_m[NS][k], {FRAC_BITS{1'b0}}};
        end
    end
    for (genvar g = 0; g < ND; g++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_d_v[g+1] <= 1'b0;
            else if (adv) r_d_v[g+1] <= r_d_v[g];
        end
        always_ff @(posedge i_clk) begin
            logic [RW-1:0] sh;
            if (adv) begin
                r_d_len[g+1] <= r_d_len[g]; r_d_in[g+1] <= r_d_in[g];
                r_d_ng[g+1] <= r_d_ng[g]; r_d_z[g+1] <= r_d_z[g];
                for (int k = 0; k < 3; k++) begin
                    sh = {r_d_rem[g][k][RW-2:0], r_d_q[g][k][QW-1]};
                    if (sh >= RW'(r_d_len[g])) begin
                        r_d_rem[g+1][k] <= sh - RW'(r_d_len[g]);
                        r_d_q[g+1][k] <= {r_d_q[g][k][QW-2:0], 1'b1};
                    end else begin
                        r_d_rem[g+1][k] <= sh;
                        r_d_q[g+1][k] <= {r_d_q[g][k][QW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // output register
    logic [127:0] r_tdata;
    logic r_tvalid, r_tuser;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_tvalid <= 1'b0;
        else if (adv) r_tvalid <= r_d_v[ND];
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_tuser <= r_d_z[ND];
            if (r_d_z[ND]) begin
                for (int k = 0; k < 4; k++) r_tdata[k*CW +: CW] <= r_d_in[ND][k];
            end else begin
                for (int k = 0; k < 3; k++)
                    r_tdata[k*CW +: CW] <= r_d_ng[ND][k] ? CW'(-r_d_q[ND][k])
                                                         : CW'(r_d_q[ND][k]);
                r_tdata[3*CW +: CW] <= CW'(1) << FRAC_BITS;
            end
        end
    end
    assign m_axis_tvalid = r_tvalid;
    assign m_axis_tdata  = r_tdata;
    assign m_axis_tuser  = r_tuser;

    `include "vector_normalize_3d_assert.svh"
    `VN3_ASSERT_NXT(a_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && m_axis_tvalid, "output changed under stall")
    `VN3_ASSERT_IMP(a_wone, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[3*CW +: CW] == CW'(1) << FRAC_BITS, "w not one")
    `VN3_ASSERT_IMP(a_zlen, r_s_v[NS] && len_f == '0, zero_f, "zero length not flagged")
endmodule
